>>> rtl/lbs_pkg.sv
// Package for the linear blend vertex skinner: item and result types,
// opcodes and fixed constants. No dependencies.
package lbs_pkg;

  localparam int WORDS_PER_BONE = 12;
  localparam int NUM_INF        = 4;
  localparam int WEIGHT_FRAC    = 15;
  localparam int FQ_DEPTH       = 2;
  localparam int OQ_DEPTH       = 4;
  localparam logic [15:0] WEIGHT_ONE = 16'h8000;

  typedef enum logic {
    OP_SKIN  = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [5:0]  slot;
    logic [3:0]  word;
    logic [31:0] value;
    logic [2:0][31:0] pos;
    logic [2:0][31:0] nrm;
    logic [31:0] bones;
    logic [63:0] weights;
  } item_t;

  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0][31:0] nrm;
  } res_t;

  // Bone store clearing pass: row address swept after reset.
  typedef struct packed {
    logic       active;
    logic [7:0] addr;
  } clr_t;

  function automatic logic [31:0] sat32(input logic signed [65:0] v);
    logic [31:0] r;
    if (v > 66'sd2147483647) begin
      r = 32'h7fff_ffff;
    end else if (v < -66'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/linear_blend_vertex_skinner_top.sv
// Top level of the four-bone linear blend vertex skinner.
// Uses lbs_pkg, lbs_front, lbs_back and lbs_queue.
//
// Input channel: an item is taken at a clock edge with push high and full low.
// A matrix write item (in_operation = 1) loads one Q16.16 word of one bone
// matrix and gives no result; writes to a word beyond eleven or to a bone
// beyond the store are dropped. A skin item (in_operation = 0) gives one
// result: the vertex position and normal transformed by the blended matrix.
// Result channel: the oldest result is on out_* while empty is low and is
// taken at a clock edge with pop high and empty low.
// A skin item makes one read of the single-ported bone store per influence,
// four in all; a matrix write makes one write. Items are queued in front,
// so the next beat is taken while a skin item is at work. After reset the
// bone store is loaded with identity matrices by a clearing pass, during
// which full stays high. The configuration register cfg_wdata (one-bone
// mode) is to be written with cfg_we only while idle, by the user; the block
// itself does not enforce this.
// When the receiver stalls, up to four results wait in the result queue and
// the back end holds further skin items until a slot frees up.
module linear_blend_vertex_skinner_top #(
  parameter int MAX_BONES = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        push,
  output logic        full,
  input  logic        in_operation,
  input  logic [5:0]  in_bone_slot,
  input  logic [3:0]  in_word_index,
  input  logic signed [31:0] in_word_value,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic signed [31:0] in_nrm_x,
  input  logic signed [31:0] in_nrm_y,
  input  logic signed [31:0] in_nrm_z,
  input  logic [31:0] in_influence_bones,
  input  logic [63:0] in_influence_weights,
  output logic        empty,
  input  logic        pop,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  output logic signed [31:0] out_nrm_x,
  output logic signed [31:0] out_nrm_y,
  output logic signed [31:0] out_nrm_z
);
  import lbs_pkg::*;

  logic  mode_r;
  item_t in_item, q_item;
  clr_t  clr;
  res_t  res, oq_res;
  logic  q_valid, q_pop, res_valid, oq_full, res_taken;
  logic [$bits(res_t)-1:0] oq_dout;

  // The one configuration register: one-bone mode.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
    end
  end

  always_comb begin
    in_item.op      = op_t'(in_operation);
    in_item.slot    = in_bone_slot;
    in_item.word    = in_word_index;
    in_item.value   = in_word_value;
    in_item.pos     = {in_pos_z, in_pos_y, in_pos_x};
    in_item.nrm     = {in_nrm_z, in_nrm_y, in_nrm_x};
    in_item.bones   = in_influence_bones;
    in_item.weights = in_influence_weights;
  end

  lbs_front #(.MAX_BONES(MAX_BONES)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .full   (full),
    .in_item(in_item),
    .q_pop  (q_pop),
    .q_valid(q_valid),
    .q_item (q_item),
    .clr    (clr)
  );

  assign res_taken = pop && !empty;

  lbs_back #(.MAX_BONES(MAX_BONES), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .mode     (mode_r),
    .clr      (clr),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .res_taken(res_taken),
    .res_valid(res_valid),
    .res      (res)
  );

  // Result queue; the back end reserves a slot before it starts an item.
  lbs_queue #(.WIDTH($bits(res_t)), .DEPTH(OQ_DEPTH)) u_oq (
    .clk  (clk),
    .rst_n(rst_n),
    .push (res_valid),
    .din  (res),
    .full (oq_full),
    .pop  (pop),
    .dout (oq_dout),
    .empty(empty)
  );

  assign oq_res    = res_t'(oq_dout);
  assign out_pos_x = oq_res.pos[0];
  assign out_pos_y = oq_res.pos[1];
  assign out_pos_z = oq_res.pos[2];
  assign out_nrm_x = oq_res.nrm[0];
  assign out_nrm_y = oq_res.nrm[1];
  assign out_nrm_z = oq_res.nrm[2];

  a_oq_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !oq_full) else $error("result pushed into a full queue");
  a_no_take_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr.active |-> full) else $error("input taken during clearing pass");
  a_mode_idle: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> $stable(mode_r) || $past(!q_valid)) else $error("mode changed mid item");
endmodule

>>> rtl/lbs_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module lbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                     wdata,
  output logic [WIDTH-1:0]                     rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

>>> rtl/lbs_queue.sv
// Small first-in first-out queue with push/full and pop/empty sides.
// No dependencies; DEPTH is a power of two.
module lbs_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] data_r [DEPTH];
  logic [AW-1:0]    wr_r, rd_r;
  logic [AW:0]      cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = data_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (do_pop) begin
        rd_r <= rd_r + 1'b1;
      end
      cnt_r <= cnt_r + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      data_r[wr_r] <= din;
    end
  end
endmodule

>>> rtl/lbs_front.sv
// Front end: accepts input beats, drops out-of-range matrix writes, queues
// the rest, and runs the bone store clearing pass. Uses lbs_pkg, lbs_queue.
module lbs_front #(
  parameter int MAX_BONES = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  output logic          full,
  input  lbs_pkg::item_t in_item,
  input  logic          q_pop,
  output logic          q_valid,
  output lbs_pkg::item_t q_item,
  output lbs_pkg::clr_t clr
);
  import lbs_pkg::*;

  localparam int CW = $clog2(MAX_BONES + 1);

  logic          clearing_r;
  logic [CW-1:0] clr_cnt_r;
  logic          q_full, q_empty, keep, q_push;
  logic [$bits(item_t)-1:0] q_dout;

  assign keep   = (in_item.op == OP_SKIN) ||
                  ((9'(in_item.slot) < 9'(MAX_BONES)) &&
                   (in_item.word < 4'(WORDS_PER_BONE)));
  assign full   = clearing_r || q_full;
  assign q_push = push && !full && keep;

  assign clr.active = clearing_r;
  assign clr.addr   = 8'(clr_cnt_r);
  assign q_valid    = !q_empty;
  assign q_item     = item_t'(q_dout);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clearing_r) begin
      if (clr_cnt_r == CW'(MAX_BONES - 1)) begin
        clearing_r <= 1'b0;
      end
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  lbs_queue #(.WIDTH($bits(item_t)), .DEPTH(FQ_DEPTH)) u_fq (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .din  (in_item),
    .full (q_full),
    .pop  (q_pop),
    .dout (q_dout),
    .empty(q_empty)
  );
endmodule

>>> rtl/lbs_back.sv
// Back end: bone store, blend sequencer and transform pipeline.
// Uses lbs_pkg and lbs_ram.
module lbs_back #(
  parameter int MAX_BONES = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           mode,
  input  lbs_pkg::clr_t  clr,
  input  logic           q_valid,
  input  lbs_pkg::item_t q_item,
  output logic           q_pop,
  input  logic           res_taken,
  output logic           res_valid,
  output lbs_pkg::res_t  res
);
  import lbs_pkg::*;

  localparam int BAW = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
  localparam int CRW = $clog2(OQ_DEPTH + 1);

  // Sequencer.
  item_t          cur_r, src;
  logic           busy_r, start, wr_go, issue, inr, last;
  logic [1:0]     cnt_r, inf;
  logic [7:0]     bone;
  logic [15:0]    wt, wt_eff;
  logic [CRW-1:0] credit_r;
  logic [BAW-1:0] ram_addr;
  logic [31:0]    rdata [WORDS_PER_BONE];

  assign start = !clr.active && q_valid && (q_item.op == OP_SKIN) && !busy_r &&
                 (credit_r < CRW'(OQ_DEPTH));
  assign wr_go = !clr.active && q_valid && (q_item.op == OP_WRITE) && !busy_r;
  assign q_pop = start || wr_go;
  assign issue = start || busy_r;
  assign src   = busy_r ? cur_r : q_item;
  assign inf   = busy_r ? cnt_r : 2'd0;
  assign bone  = src.bones[8*inf +: 8];
  assign wt    = src.weights[16*inf +: 16];
  assign inr   = (9'(bone) < 9'(MAX_BONES));
  assign last  = (inf == 2'(NUM_INF - 1));

  // In one-bone mode influence zero gets weight one, the rest weight zero.
  always_comb begin
    if (mode) begin
      wt_eff = (inf == 2'd0) ? WEIGHT_ONE : 16'd0;
    end else begin
      wt_eff = wt;
    end
    if (clr.active) begin
      ram_addr = BAW'(clr.addr);
    end else if (wr_go) begin
      ram_addr = BAW'(q_item.slot);
    end else begin
      ram_addr = BAW'(bone);
    end
  end

  for (genvar k = 0; k < WORDS_PER_BONE; k++) begin : g_col
    logic        we;
    logic [31:0] wd;
    assign we = clr.active || (wr_go && (q_item.word == 4'(k)));
    assign wd = clr.active ? ((k == 0 || k == 5 || k == 10) ?
                              (32'd1 << FRAC_BITS) : 32'd0) : q_item.value;
    lbs_ram #(.WIDTH(32), .DEPTH(MAX_BONES)) u_ram (
      .clk  (clk),
      .we   (we),
      .addr (ram_addr),
      .wdata(wd),
      .rdata(rdata[k])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      cnt_r    <= '0;
      credit_r <= '0;
    end else begin
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 2'd1;
      end else if (busy_r) begin
        if (last) begin
          busy_r <= 1'b0;
        end
        cnt_r <= cnt_r + 1'b1;
      end
      credit_r <= credit_r + CRW'(start) - CRW'(res_taken);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cur_r <= q_item;
    end
  end

  // Stage 1: tags aligned with the registered bone store read.
  logic             s1_v_r, s1_first_r, s1_last_r, s1_inr_r;
  logic [15:0]      s1_w_r;
  res_t             s1_vx_r, s2_vx_r, s3_vx_r, s4_vx_r;
  // Stage 2: weighted words.
  logic             s2_v_r, s2_first_r, s2_last_r;
  logic signed [48:0] prod_r [WORDS_PER_BONE];
  // Stage 3: blend accumulators.
  logic             s3_v_r;
  logic signed [50:0] acc_r [WORDS_PER_BONE];
  // Stage 4: blended matrix.
  logic             s4_v_r;
  logic [31:0]      m_r [WORDS_PER_BONE];
  // Stage 5: transform products.
  logic             s5_v_r;
  logic signed [63:0] pp_r [3][3];
  logic signed [63:0] np_r [3][3];
  logic [31:0]      tr_r [3];
  // Stage 6: result.
  logic             res_v_r;
  res_t             res_r, res_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      s5_v_r  <= 1'b0;
      res_v_r <= 1'b0;
    end else begin
      s1_v_r  <= issue;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= s2_v_r && s2_last_r;
      s4_v_r  <= s3_v_r;
      s5_v_r  <= s4_v_r;
      res_v_r <= s5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_first_r <= (inf == 2'd0);
    s1_last_r  <= last;
    s1_inr_r   <= inr;
    s1_w_r     <= wt_eff;
    s1_vx_r.pos <= src.pos;
    s1_vx_r.nrm <= src.nrm;
    s2_first_r <= s1_first_r;
    s2_last_r  <= s1_last_r;
    s2_vx_r    <= s1_vx_r;
    for (int k = 0; k < WORDS_PER_BONE; k++) begin
      if (s1_inr_r) begin
        prod_r[k] <= $signed(rdata[k]) * $signed({1'b0, s1_w_r});
      end else begin
        prod_r[k] <= '0;
      end
      if (s2_v_r) begin
        acc_r[k] <= s2_first_r ? 51'(prod_r[k]) : acc_r[k] + 51'(prod_r[k]);
      end
      m_r[k] <= sat32(66'((acc_r[k] + 51'sd16384) >>> WEIGHT_FRAC));
    end
    if (s2_v_r && s2_last_r) begin
      s3_vx_r <= s2_vx_r;
    end
    s4_vx_r <= s3_vx_r;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        pp_r[r][c] <= $signed(m_r[r*4+c]) * $signed(s4_vx_r.pos[c]);
        np_r[r][c] <= $signed(m_r[r*4+c]) * $signed(s4_vx_r.nrm[c]);
      end
      tr_r[r] <= m_r[r*4+3];
    end
    res_r <= res_nxt;
  end

  // Each product is rounded on its own before the row sum.
  always_comb begin
    logic signed [65:0] sp, sn, tp, tn;
    for (int r = 0; r < 3; r++) begin
      sp = 66'($signed(tr_r[r]));
      sn = '0;
      for (int c = 0; c < 3; c++) begin
        tp = 66'(pp_r[r][c]);
        tn = 66'(np_r[r][c]);
        sp = sp + ((tp + (66'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
        sn = sn + ((tn + (66'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
      end
      res_nxt.pos[r] = sat32(sp);
      res_nxt.nrm[r] = sat32(sn);
    end
  end

  assign res_valid = res_v_r;
  assign res       = res_r;

  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    credit_r <= CRW'(OQ_DEPTH)) else $error("credit count above result queue depth");
  a_write_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_go && issue)) else $error("matrix write collides with bone read");
  a_res_credit: assert property (@(posedge clk) disable iff (!rst_n)
    res_v_r |-> (credit_r != '0)) else $error("result without a reserved slot");
  a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
    clr.active |-> !busy_r && !q_pop) else $error("work during clearing pass");
endmodule
